FILE: design/bbd_pkg.sv
`timescale 1ns / 1ps

package bbd_pkg;

    // sample and register widths
    localparam int SAMPLE_W   = 8;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // line buffer depth default
    localparam int DEFAULT_MAX_WIDTH = 1024;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    // values after reset
    localparam logic [WIDTH_W-1:0]  RESET_FRAME_WIDTH  = 11'd320;
    localparam logic [HEIGHT_W-1:0] RESET_FRAME_HEIGHT = 12'd200;

    // 3x3 neighborhood, indexed [row][col], row 0 on top, col 0 on the left
    typedef logic [2:0][2:0][SAMPLE_W-1:0] t_window;

    // interpolated pixel
    typedef struct packed {
        logic [SAMPLE_W-1:0] red;
        logic [SAMPLE_W-1:0] green;
        logic [SAMPLE_W-1:0] blue;
    } t_rgb;

endpackage

FILE: design/bayer_bilinear_demosaic_core.sv
`timescale 1ns / 1ps
// o_valid rises once the request of the sample one row below and one column right of the pixel
//   has been accepted and has passed the memory read, then the output register
// throughput: one sample per cycle, one line memory read and one write per cycle; the input
//   stalls only while a pixel waits in the output register with i_ready low
// reset: synchronous, clears position counters, valid flags, restores 320x200;
//   line memory and window are not cleared (unwritten entries only feed the dropped border)
module bayer_bilinear_demosaic_core
    import bbd_pkg::*;
#(
    parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // sample request channel
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [SAMPLE_W-1:0]   i_raw_sample,
    // pixel request channel
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [SAMPLE_W-1:0]   o_red,
    output logic [SAMPLE_W-1:0]   o_green,
    output logic [SAMPLE_W-1:0]   o_blue,
    output logic                  o_row_end,
    output logic                  o_frame_end,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int MW = 2 * SAMPLE_W;

    logic [WIDTH_W-1:0]  r_frame_width;
    logic [HEIGHT_W-1:0] r_frame_height;
    logic [CW-1:0]       r_col;
    logic [HEIGHT_W-1:0] r_row;
    logic [CW-1:0]       w_last_col;
    logic [HEIGHT_W-1:0] w_last_row;
    logic                w_in_acc;
    logic                w_cfg_acc;

    // stage 1: sample with its position, line data arriving from memory
    logic                r_s1_valid;
    logic [SAMPLE_W-1:0] r_s1_sample;
    logic [CW-1:0]       r_s1_col;
    logic [HEIGHT_W-1:0] r_s1_row;
    logic                w_s1_emit;
    logic                w_s1_adv;
    logic                w_o_load;

    // line memory: upper byte two rows above, lower byte one row above
    logic [MW-1:0]       r_line_mem [MAX_WIDTH];
    logic [MW-1:0]       r_rd_data;

    // two previous columns, top to bottom
    logic [SAMPLE_W-1:0] r_win [6];
    t_window             w_win;
    t_rgb                w_rgb;

    logic                r_o_valid;
    t_rgb                r_o_rgb;
    logic                r_o_row_end;
    logic                r_o_frame_end;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_acc   = i_cfg_valid & o_cfg_ready;

    // effective frame size, clamped
    always_comb begin
        if (r_frame_width < 11'd3) begin
            w_last_col = CW'(2);
        end else if (32'(r_frame_width) >= MAX_WIDTH) begin
            w_last_col = CW'(MAX_WIDTH - 1);
        end else begin
            w_last_col = CW'(r_frame_width - 11'd1);
        end
        if (r_frame_height < 12'd3) begin
            w_last_row = 12'd2;
        end else begin
            w_last_row = r_frame_height - 12'd1;
        end
    end

    // handshake and stage advance
    assign w_s1_emit = (r_s1_row >= 12'd2) && (r_s1_col >= CW'(2));
    assign w_s1_adv  = r_s1_valid && (!w_s1_emit || !r_o_valid || i_ready);
    assign w_o_load  = w_s1_adv && w_s1_emit;
    assign o_ready   = !r_s1_valid || w_s1_adv;
    assign w_in_acc  = i_valid && o_ready;

    // configuration registers and raster position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RESET_FRAME_WIDTH;
            r_frame_height <= RESET_FRAME_HEIGHT;
            r_col          <= '0;
            r_row          <= '0;
        end else if (w_cfg_acc) begin
            unique case (i_cfg_index)
                REG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_data[WIDTH_W-1:0];
                    r_col         <= '0;
                    r_row         <= '0;
                end
                REG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data[HEIGHT_W-1:0];
                    r_col          <= '0;
                    r_row          <= '0;
                end
                default: begin
                end
            endcase
        end else if (w_in_acc) begin
            if (r_col == w_last_col) begin
                r_col <= '0;
                r_row <= (r_row == w_last_row) ? '0 : r_row + 12'd1;
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_sample <= i_raw_sample;
            r_s1_col    <= r_col;
            r_s1_row    <= r_row;
        end
    end

    // line memory: read at the new sample's column, write back the shifted pair;
    // an entry is read again only a full row after its write, so no forwarding is needed
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_rd_data <= r_line_mem[r_col];
        end
        if (w_s1_adv) begin
            r_line_mem[r_s1_col] <= {r_rd_data[SAMPLE_W-1:0], r_s1_sample};
        end
    end

    // window column shift
    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= r_rd_data[MW-1:SAMPLE_W];
            r_win[4] <= r_rd_data[SAMPLE_W-1:0];
            r_win[5] <= r_s1_sample;
        end
    end

    // assemble the 3x3 neighborhood
    always_comb begin
        w_win[0][0] = r_win[0];
        w_win[1][0] = r_win[1];
        w_win[2][0] = r_win[2];
        w_win[0][1] = r_win[3];
        w_win[1][1] = r_win[4];
        w_win[2][1] = r_win[5];
        w_win[0][2] = r_rd_data[MW-1:SAMPLE_W];
        w_win[1][2] = r_rd_data[SAMPLE_W-1:0];
        w_win[2][2] = r_s1_sample;
    end

    // center is one row up and one column left: its parity is the opposite
    bbd_interp u_interp (
        .i_win     (w_win),
        .i_row_odd (!r_s1_row[0]),
        .i_col_odd (!r_s1_col[0]),
        .o_rgb     (w_rgb)
    );

    // output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_o_load) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_o_load) begin
            r_o_rgb       <= w_rgb;
            r_o_row_end   <= (r_s1_col == w_last_col);
            r_o_frame_end <= (r_s1_col == w_last_col) && (r_s1_row == w_last_row);
        end
    end

    assign o_valid     = r_o_valid;
    assign o_red       = r_o_rgb.red;
    assign o_green     = r_o_rgb.green;
    assign o_blue      = r_o_rgb.blue;
    assign o_row_end   = r_o_row_end;
    assign o_frame_end = r_o_frame_end;

endmodule

FILE: design/bbd_interp.sv
`timescale 1ns / 1ps

module bbd_interp
    import bbd_pkg::*;
(
    input  t_window i_win,
    input  logic    i_row_odd,
    input  logic    i_col_odd,
    output t_rgb    o_rgb
);

    logic [SAMPLE_W+1:0] w_cross_sum;
    logic [SAMPLE_W+1:0] w_corner_sum;
    logic [SAMPLE_W:0]   w_horiz_sum;
    logic [SAMPLE_W:0]   w_vert_sum;
    logic [SAMPLE_W-1:0] w_cross;
    logic [SAMPLE_W-1:0] w_corner;
    logic [SAMPLE_W-1:0] w_horiz;
    logic [SAMPLE_W-1:0] w_vert;
    logic [SAMPLE_W-1:0] w_center;

    // neighbor sums
    always_comb begin
        w_horiz_sum  = {1'b0, i_win[1][0]} + {1'b0, i_win[1][2]};
        w_vert_sum   = {1'b0, i_win[0][1]} + {1'b0, i_win[2][1]};
        w_cross_sum  = {1'b0, w_horiz_sum} + {1'b0, w_vert_sum};
        w_corner_sum = {2'b00, i_win[0][0]} + {2'b00, i_win[0][2]}
                     + {2'b00, i_win[2][0]} + {2'b00, i_win[2][2]};
        w_horiz  = w_horiz_sum[SAMPLE_W:1];
        w_vert   = w_vert_sum[SAMPLE_W:1];
        w_cross  = w_cross_sum[SAMPLE_W+1:2];
        w_corner = w_corner_sum[SAMPLE_W+1:2];
        w_center = i_win[1][1];
    end

    // pick colors by site: red on odd/odd, blue on even/even, green otherwise
    always_comb begin
        case ({i_row_odd, i_col_odd})
            2'b11: begin
                o_rgb = '{red: w_center, green: w_cross, blue: w_corner};
            end
            2'b10: begin
                o_rgb = '{red: w_horiz, green: w_center, blue: w_vert};
            end
            2'b01: begin
                o_rgb = '{red: w_vert, green: w_center, blue: w_horiz};
            end
            default: begin
                o_rgb = '{red: w_corner, green: w_cross, blue: w_center};
            end
        endcase
    end

endmodule

FILE: design/bbd_checker.sv
`timescale 1ns / 1ps

module bbd_checker
    import bbd_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_ready,
    input logic                o_valid,
    input logic                i_ready,
    input logic [SAMPLE_W-1:0] o_red,
    input logic [SAMPLE_W-1:0] o_green,
    input logic [SAMPLE_W-1:0] o_blue,
    input logic                o_row_end,
    input logic                o_frame_end
);

    // a stalled pixel holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_red) && $stable(o_green)
            && $stable(o_blue) && $stable(o_row_end) && $stable(o_frame_end))
        else $error("pixel changed while stalled");

    // frame end only on a row end
    a_frame_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_end |-> o_row_end)
        else $error("frame end without row end");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("pixel valid after reset");

    // input only backs up behind a stalled output
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("sample request refused with output free");

endmodule

bind bayer_bilinear_demosaic_core bbd_checker u_bbd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_red       (o_red),
    .o_green     (o_green),
    .o_blue      (o_blue),
    .o_row_end   (o_row_end),
    .o_frame_end (o_frame_end)
);
